>>> rtl/fixed_point_iir_filter_core_assert.svh
// Assertion macros shared by the IIR filter RTL.
// Each macro checks one property on the rising edge of i_clk, held off during reset.
`ifndef FIXED_POINT_IIR_FILTER_CORE_ASSERT_SVH
`define FIXED_POINT_IIR_FILTER_CORE_ASSERT_SVH

// Same-cycle implication: when the antecedent holds, the consequent holds too.
`define IIR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when the antecedent holds, the consequent holds in the next cycle.
`define IIR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/iir_pkg.sv
// Package for the fixed-point IIR filter core: sizes, register indexes, state type.
// No dependencies; used by fixed_point_iir_filter_core.
package iir_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int NUM_B     = 3;
    localparam int NUM_A     = 3;
    localparam int NUM_COEF  = 6;
    localparam int CFG_IDX_W = 3;

    // Products summed per sample, and the accumulator width that holds their sum.
    localparam int NUM_TERMS = NUM_B + NUM_A - 1;
    localparam int ACC_W     = DATA_W + $clog2(NUM_TERMS);

    // Divider: magnitude of the accumulator shifted up by the fraction, two bits a cycle.
    localparam int DIV_STEPS = (ACC_W - 1 + FRAC_BITS + 1) / 2;
    localparam int DVD_W     = 2 * DIV_STEPS;

    localparam logic [CFG_IDX_W-1:0] CFG_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_A0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_A1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_A2 = 3'd5;

    localparam logic [DATA_W-1:0] COEF_ONE = 32'h0001_0000;
    localparam logic [DATA_W-1:0] SAT_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN  = 32'h8000_0000;

    localparam logic FUNC_FILTER = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DSET,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

>>> rtl/fixed_point_iir_filter_core.sv
// Direct-form-I biquad IIR filter core on signed Q16.16 samples.
// Depends on iir_pkg and fixed_point_iir_filter_core_assert.svh.

// A filter word is accepted in idle and then runs five multiply/accumulate passes, each a
// multiply step and an accumulate step, through one shared 32x32 multiplier, then a step
// that sets up the divide, then a two-bit-per-cycle restoring divider that divides the
// accumulator by a0, and last a step that saturates and loads the result into the output
// register. With a0 at zero the divide is skipped. The input side is not ready until the
// core is back in idle, so a new filter word cannot be accepted before the last one is
// finished. A clear word (tuser high) zeroes both histories in the cycle it is accepted
// and gives no result, so the next word can follow in the next cycle. A finished result
// waits in the output register while the next word is accepted; if it is still waiting
// when the next result is ready, the core holds in its last step until it is taken.
// Coefficients may be written at any time the core is idle; indexes 6 and 7 are ignored.
`include "fixed_point_iir_filter_core_assert.svh"

module fixed_point_iir_filter_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [iir_pkg::DATA_W-1:0]       i_s_tdata,   // [31:0] sample_in
    input  logic                             i_s_tuser,   // [0] func
    // Output stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [iir_pkg::DATA_W-1:0]       o_m_tdata,   // [31:0] sample_out
    // Coefficient write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [iir_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [iir_pkg::DATA_W-1:0]       i_cfg_data
);

    import iir_pkg::*;

    localparam int IDX_W  = $clog2(NUM_TERMS + 1);
    localparam int DCNT_W = $clog2(DIV_STEPS);
    localparam logic [DVD_W-1:0] Q_MAX     = DVD_W'(64'h7FFF_FFFF);
    localparam logic [DVD_W-1:0] Q_MIN_MAG = DVD_W'(64'h8000_0000);

    t_state                   r_state, n_state;
    logic [DATA_W-1:0]        r_coef [NUM_COEF];
    logic [DATA_W-1:0]        r_xh   [3];
    logic [DATA_W-1:0]        r_yh   [2];
    logic [IDX_W-1:0]         r_idx;
    logic [DCNT_W-1:0]        r_dcnt;
    logic signed [2*DATA_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [DVD_W-1:0]         r_quo;
    logic [DATA_W-1:0]        r_rem;
    logic [DATA_W-1:0]        r_dmag;
    logic                     r_neg;
    logic                     r_aneg;
    logic                     r_dz;
    logic                     r_ovalid;
    logic [DATA_W-1:0]        r_out;

    logic                     w_s_acc;
    logic                     w_load_out;
    logic                     w_is_b;
    logic [CFG_IDX_W-1:0]     w_idx3;
    logic [CFG_IDX_W-1:0]     w_aoff;
    logic [DATA_W-1:0]        w_coef_sel;
    logic [DATA_W-1:0]        w_hist_sel;
    logic signed [2*DATA_W-1:0] w_shift;
    logic [DATA_W-1:0]        w_term;
    logic signed [ACC_W-1:0]  w_term_ext;
    logic signed [ACC_W-1:0]  w_acc_abs;
    logic [DATA_W-1:0]        w_a0;
    logic [DATA_W-1:0]        w_a0_mag;
    logic [DATA_W:0]          w_t1, w_t2;
    logic [DATA_W-1:0]        w_rem1, w_rem2;
    logic                     w_b1, w_b2;
    logic [DATA_W-1:0]        w_y;

    assign w_s_acc     = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_out;

    // Outputs of the sequencer.
    always_comb begin
        o_s_tready = (r_state == ST_IDLE);
        w_load_out = (r_state == ST_DONE) && (!r_ovalid || i_m_tready);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_s_acc && (i_s_tuser == FUNC_FILTER)) n_state = ST_MUL;
            end
            ST_MUL:  n_state = ST_ACC;
            ST_ACC: begin
                if (r_idx == IDX_W'(NUM_TERMS - 1)) n_state = ST_DSET;
                else n_state = ST_MUL;
            end
            ST_DSET: begin
                if (r_dz) n_state = ST_DONE;
                else n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_dcnt == DCNT_W'(DIV_STEPS - 1)) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_load_out) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Term selection: feedforward terms first, then feedback terms.
    always_comb begin
        w_idx3 = CFG_IDX_W'(r_idx);
        w_is_b = (r_idx < IDX_W'(NUM_B));
        w_aoff = w_idx3 - CFG_IDX_W'(NUM_B);
        if (w_is_b) begin
            w_coef_sel = r_coef[w_idx3];
            w_hist_sel = r_xh[w_idx3[1:0]];
        end else begin
            w_coef_sel = r_coef[CFG_A1 + w_aoff];
            w_hist_sel = r_yh[w_aoff[0]];
        end
    end

    // Arithmetic shift of the product is a floor; then saturate to 32 bits.
    always_comb begin
        w_shift = r_prod >>> FRAC_BITS;
        if (w_shift > $signed({{DATA_W{1'b0}}, SAT_MAX})) begin
            w_term = SAT_MAX;
        end else if (w_shift < $signed({{DATA_W{1'b1}}, SAT_MIN})) begin
            w_term = SAT_MIN;
        end else begin
            w_term = w_shift[DATA_W-1:0];
        end
        w_term_ext = ACC_W'($signed(w_term));
    end

    // Divide setup values.
    always_comb begin
        w_a0      = r_coef[CFG_A0];
        w_a0_mag  = w_a0[DATA_W-1] ? (~w_a0 + 1'b1) : w_a0;
        w_acc_abs = r_acc[ACC_W-1] ? -r_acc : r_acc;
    end

    // Two restoring divide steps per cycle; the remainder stays below the divisor.
    always_comb begin
        w_t1   = {r_rem, r_quo[DVD_W-1]};
        w_b1   = (w_t1 >= {1'b0, r_dmag});
        w_rem1 = w_b1 ? DATA_W'(w_t1 - {1'b0, r_dmag}) : w_t1[DATA_W-1:0];
        w_t2   = {w_rem1, r_quo[DVD_W-2]};
        w_b2   = (w_t2 >= {1'b0, r_dmag});
        w_rem2 = w_b2 ? DATA_W'(w_t2 - {1'b0, r_dmag}) : w_t2[DATA_W-1:0];
    end

    // Sign and saturation of the quotient.
    always_comb begin
        if (r_dz) begin
            w_y = r_aneg ? SAT_MIN : SAT_MAX;
        end else if (r_neg) begin
            w_y = (r_quo > Q_MIN_MAG) ? SAT_MIN : (~r_quo[DATA_W-1:0] + 1'b1);
        end else begin
            w_y = (r_quo > Q_MAX) ? SAT_MAX : r_quo[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_coef[CFG_B0] <= COEF_ONE;
            r_coef[CFG_B1] <= '0;
            r_coef[CFG_B2] <= '0;
            r_coef[CFG_A0] <= COEF_ONE;
            r_coef[CFG_A1] <= '0;
            r_coef[CFG_A2] <= '0;
            r_xh[0]  <= '0;
            r_xh[1]  <= '0;
            r_xh[2]  <= '0;
            r_yh[0]  <= '0;
            r_yh[1]  <= '0;
            r_idx    <= '0;
            r_dcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready && (i_cfg_index <= CFG_A2)) begin
                r_coef[i_cfg_index] <= i_cfg_data;
            end

            // A new result may replace the one taken in the same cycle.
            if (w_load_out) begin
                r_ovalid <= 1'b1;
            end else if (o_m_tvalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    r_idx <= '0;
                    r_acc <= '0;
                    if (w_s_acc) begin
                        if (i_s_tuser == FUNC_CLEAR) begin
                            r_xh[0] <= '0;
                            r_xh[1] <= '0;
                            r_xh[2] <= '0;
                            r_yh[0] <= '0;
                            r_yh[1] <= '0;
                        end else begin
                            r_xh[2] <= r_xh[1];
                            r_xh[1] <= r_xh[0];
                            r_xh[0] <= i_s_tdata;
                        end
                    end
                end
                ST_MUL: begin
                    r_prod <= $signed(w_coef_sel) * $signed(w_hist_sel);
                end
                ST_ACC: begin
                    r_acc <= w_is_b ? (r_acc + w_term_ext) : (r_acc - w_term_ext);
                    r_idx <= r_idx + 1'b1;
                    // The divisor test is ready by the time the divide is set up.
                    r_dz  <= (w_a0 == '0);
                end
                ST_DSET: begin
                    r_aneg <= r_acc[ACC_W-1];
                    r_neg  <= r_acc[ACC_W-1] ^ w_a0[DATA_W-1];
                    r_dmag <= w_a0_mag;
                    r_quo  <= DVD_W'({w_acc_abs[ACC_W-2:0], {FRAC_BITS{1'b0}}});
                    r_rem  <= '0;
                    r_dcnt <= '0;
                end
                ST_DIV: begin
                    r_quo  <= {r_quo[DVD_W-3:0], w_b1, w_b2};
                    r_rem  <= w_rem2;
                    r_dcnt <= r_dcnt + 1'b1;
                end
                ST_DONE: begin
                    if (w_load_out) begin
                        r_out    <= w_y;
                        r_yh[1]  <= r_yh[0];
                        r_yh[0]  <= w_y;
                    end
                end
                default: ;
            endcase
        end
    end

    `IIR_ASSERT_NXT(a_filter_starts, w_s_acc && (i_s_tuser == FUNC_FILTER),
        r_state == ST_MUL, "filter word did not start the multiply pass")
    `IIR_ASSERT_NXT(a_clear_zeroes, w_s_acc && (i_s_tuser == FUNC_CLEAR),
        (r_xh[0] == '0) && (r_yh[0] == '0) && (r_state == ST_IDLE),
        "clear word did not zero the histories")
    `IIR_ASSERT_NXT(a_done_holds, (r_state == ST_DONE) && r_ovalid && !i_m_tready,
        (r_state == ST_DONE) && r_ovalid, "pending result was overwritten")
    `IIR_ASSERT_IMP(a_idx_range, (r_state == ST_MUL) || (r_state == ST_ACC),
        r_idx < IDX_W'(NUM_TERMS), "term index out of range")

endmodule
